// ----- src/nalsp_pkg.sv -----
// Package for the Annex-B NAL unit splitter: shared types, constants and
// the start-code match function. No dependencies.
`default_nettype none

package nalsp_pkg;

    // Field widths
    localparam int CFG_W      = 19;
    localparam int BYTE_W     = 8;
    localparam int TYPE_W     = 5;
    localparam int HC_W       = 3;
    localparam int FILL_W     = 3;
    localparam int WINDOW_W   = 32;

    // Defaults and limits
    localparam int COUNT_BITS_DEF = 19;
    localparam int CAP_MIN        = 16;
    localparam int CAP_RESET      = 256 * 1024;
    localparam logic [FILL_W-1:0] WINDOW_BYTES = 3'd4;

    // NAL unit types of interest
    localparam logic [TYPE_W-1:0] TYPE_IDR  = 5'd5;
    localparam logic [TYPE_W-1:0] TYPE_SPS  = 5'd7;
    localparam logic [TYPE_W-1:0] TYPE_PPS  = 5'd8;
    localparam logic [TYPE_W-1:0] TYPE_NONE = 5'd0;
    localparam logic [BYTE_W-1:0] TYPE_MASK = 8'h1F;

    // Header byte distance from the first start-code byte
    localparam logic [HC_W-1:0] HDR_DIST_SHORT = 3'd3;
    localparam logic [HC_W-1:0] HDR_DIST_LONG  = 3'd4;

    // Minimum count before a new start code may be recognized
    localparam int MIN_NAL_SPAN = 3;

    // Byte-level parser state, byte count kept separately (parameter width)
    typedef struct packed {
        logic [WINDOW_W-1:0] window;
        logic [FILL_W-1:0]   fill;
        logic                in_nal;
        logic [HC_W-1:0]     hdr_cnt;
        logic [TYPE_W-1:0]   cur_type;
        logic                seen_sps;
        logic                seen_pps;
        logic                seen_idr;
        logic                discard;
    } parse_state_t;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              nal_first;
        logic              nal_last;
        logic [TYPE_W-1:0] unit_type;
        logic              nal_abort;
        logic              stream_ready;
    } result_t;

    // 00 00 01 or 00 00 00 01, oldest byte first
    function automatic logic is_start_code(input logic [BYTE_W-1:0] a,
                                           input logic [BYTE_W-1:0] b,
                                           input logic [BYTE_W-1:0] c,
                                           input logic [BYTE_W-1:0] d);
        logic short_code;
        logic long_code;
        short_code = (a == 8'h00) && (b == 8'h00) && (c == 8'h01);
        long_code  = (a == 8'h00) && (b == 8'h00) && (c == 8'h00) && (d == 8'h01);
        return short_code || long_code;
    endfunction

endpackage

`default_nettype wire

// ----- src/nalsp_step.sv -----
// Per-byte update of the NAL splitter: start-code match, header capture,
// cap check and result formation. Depends on nalsp_pkg.
`default_nettype none

module nalsp_step #(
    parameter int COUNT_BITS = nalsp_pkg::COUNT_BITS_DEF
) (
    input  wire nalsp_pkg::parse_state_t   state_cur,
    input  wire logic [COUNT_BITS-1:0]     count_cur,
    input  wire logic [COUNT_BITS-1:0]     cap,
    input  wire logic [7:0]                in_byte,
    output nalsp_pkg::parse_state_t        state_new,
    output logic [COUNT_BITS-1:0]          count_new,
    output logic                           res_valid,
    output nalsp_pkg::result_t             res
);

    localparam logic [COUNT_BITS-1:0] SPAN = COUNT_BITS'(nalsp_pkg::MIN_NAL_SPAN);

    logic [7:0] b0, b1, b2, b3;
    logic       start_here;
    logic       next_here;
    logic       inside0, discard0;
    logic [COUNT_BITS-1:0] cnt0, cnt1;
    logic [nalsp_pkg::TYPE_W-1:0] type0, type1, hdr_type;
    logic [nalsp_pkg::HC_W-1:0]   hc0, hc1;
    logic sps1, pps1, idr1;

    assign b0 = state_cur.window[31:24];
    assign b1 = state_cur.window[23:16];
    assign b2 = state_cur.window[15:8];
    assign b3 = state_cur.window[7:0];
    assign hdr_type = nalsp_pkg::TYPE_W'(b0 & nalsp_pkg::TYPE_MASK);

    always_comb begin
        state_new = state_cur;
        count_new = count_cur;
        res_valid = 1'b0;
        res       = '0;
        start_here = 1'b0;
        next_here  = 1'b0;
        inside0  = state_cur.in_nal;
        discard0 = state_cur.discard;
        cnt0  = count_cur;
        cnt1  = count_cur;
        type0 = state_cur.cur_type;
        type1 = state_cur.cur_type;
        hc0   = state_cur.hdr_cnt;
        hc1   = state_cur.hdr_cnt;
        sps1  = state_cur.seen_sps;
        pps1  = state_cur.seen_pps;
        idr1  = state_cur.seen_idr;

        // window always shifts in the new byte
        state_new.window = {state_cur.window[23:0], in_byte};

        if (state_cur.fill < nalsp_pkg::WINDOW_BYTES) begin
            // lookahead still filling
            state_new.fill = state_cur.fill + 3'd1;
        end else begin
            start_here = nalsp_pkg::is_start_code(b0, b1, b2, b3) &&
                         (!state_cur.in_nal || (count_cur >= SPAN));
            if (start_here) begin
                inside0  = 1'b1;
                discard0 = 1'b0;
                cnt0     = '0;
                type0    = nalsp_pkg::TYPE_NONE;
                hc0      = (b2 == 8'h01) ? nalsp_pkg::HDR_DIST_SHORT
                                         : nalsp_pkg::HDR_DIST_LONG;
            end
            cnt1  = cnt0;
            type1 = type0;
            hc1   = hc0;

            if (inside0 && !discard0) begin
                res_valid = 1'b1;
                if (cnt0 >= cap) begin
                    // cap exceeded: abort and clear the ready flags
                    discard0 = 1'b1;
                    sps1 = 1'b0;
                    pps1 = 1'b0;
                    idr1 = 1'b0;
                    res.out_byte     = b0;
                    res.nal_first    = 1'b0;
                    res.nal_last     = 1'b1;
                    res.unit_type    = type0;
                    res.nal_abort    = 1'b1;
                    res.stream_ready = 1'b0;
                end else begin
                    // header capture on the countdown reaching zero
                    if (!start_here && (hc0 != '0)) begin
                        hc1 = hc0 - 3'd1;
                        if (hc1 == '0) begin
                            type1 = hdr_type;
                            if (hdr_type == nalsp_pkg::TYPE_SPS) begin
                                sps1 = 1'b1;
                            end else if (hdr_type == nalsp_pkg::TYPE_PPS) begin
                                pps1 = 1'b1;
                            end else if (hdr_type == nalsp_pkg::TYPE_IDR) begin
                                idr1 = 1'b1;
                            end
                        end
                    end
                    cnt1 = cnt0 + 1'b1;
                    next_here = nalsp_pkg::is_start_code(b1, b2, b3, in_byte) &&
                                (cnt1 >= SPAN);
                    res.out_byte     = b0;
                    res.nal_first    = start_here;
                    res.nal_last     = next_here;
                    res.unit_type    = type1;
                    res.nal_abort    = 1'b0;
                    res.stream_ready = sps1 && pps1 && idr1;
                end
            end

            state_new.in_nal   = inside0;
            state_new.discard  = discard0;
            state_new.hdr_cnt  = hc1;
            state_new.cur_type = type1;
            state_new.seen_sps = sps1;
            state_new.seen_pps = pps1;
            state_new.seen_idr = idr1;
            count_new          = cnt1;
        end
    end

endmodule

`default_nettype wire

// ----- src/annexb_nal_unit_splitter_top.sv -----
// Top level of the Annex-B NAL unit splitter: parser state, cap register
// and output register. Depends on nalsp_pkg and nalsp_step.
`default_nettype none

// Takes one Annex-B stream byte per clock on s_ while s_ready is high and
// gives at most one result per byte on m_: the byte from four transfers
// earlier, with first/last marks, NAL type and ready status, registered and
// shown in the cycle after the input transfer. The rate is set by the single
// per-byte state update in nalsp_step; the output register keeps accepting
// while m_ready is high, and s_ready drops only while a result waits. The
// user must write the cap (cfg_wr_en/cfg_wr_data) only while idle; the block
// does not enforce this. Values below 16 act as 16. No flush at end of stream.
module annexb_nal_unit_splitter_top #(
    parameter int COUNT_BITS = nalsp_pkg::COUNT_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [18:0] cfg_wr_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_in_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_nal_first,
    output logic             m_nal_last,
    output logic [4:0]       m_nal_type,
    output logic             m_nal_abort,
    output logic             m_stream_ready
);

    localparam int CW = (COUNT_BITS > nalsp_pkg::CFG_W) ? COUNT_BITS : nalsp_pkg::CFG_W;
    localparam logic [CW-1:0] CNT_TOP = {CW{1'b1}} >> (CW - COUNT_BITS);

    // clamp a written cap into [16, counter maximum]
    function automatic logic [COUNT_BITS-1:0] clamp_cap(input logic [18:0] v);
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (ext < CW'(nalsp_pkg::CAP_MIN)) ext = CW'(nalsp_pkg::CAP_MIN);
        if (ext > CNT_TOP) ext = CNT_TOP;
        return ext[COUNT_BITS-1:0];
    endfunction

    localparam logic [18:0] CAP_RST_VAL = 19'(nalsp_pkg::CAP_RESET);

    nalsp_pkg::parse_state_t state_reg, state_next;
    logic [COUNT_BITS-1:0]   count_reg, count_next;
    logic [COUNT_BITS-1:0]   cap_reg;
    logic                    m_valid_reg;
    nalsp_pkg::result_t      res_reg, res_next;
    logic                    res_valid;
    logic                    s_xfer;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    nalsp_step #(
        .COUNT_BITS(COUNT_BITS)
    ) u_step (
        .state_cur (state_reg),
        .count_cur (count_reg),
        .cap       (cap_reg),
        .in_byte   (s_in_byte),
        .state_new (state_next),
        .count_new (count_next),
        .res_valid (res_valid),
        .res       (res_next)
    );

    // cap register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= clamp_cap(CAP_RST_VAL);
        end else if (cfg_wr_en) begin
            cap_reg <= clamp_cap(cfg_wr_data);
        end
    end

    // parser state, advanced on every input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            count_reg <= '0;
        end else if (s_xfer) begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_valid_reg <= res_valid;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer && res_valid) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_out_byte     = res_reg.out_byte;
    assign m_nal_first    = res_reg.nal_first;
    assign m_nal_last     = res_reg.nal_last;
    assign m_nal_type     = res_reg.unit_type;
    assign m_nal_abort    = res_reg.nal_abort;
    assign m_stream_ready = res_reg.stream_ready;

endmodule

`default_nettype wire

// ----- src/nalsp_checker.sv -----
// Port-level checks for the NAL splitter top level, with its bind.
// Depends on nalsp_pkg and annexb_nal_unit_splitter_top.
`default_nettype none

module nalsp_port_sva (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_out_byte,
    input wire logic       m_nal_first,
    input wire logic       m_nal_last,
    input wire logic [4:0] m_nal_type,
    input wire logic       m_nal_abort,
    input wire logic       m_stream_ready
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_nal_type))
        else $error("stalled result changed");

    // input side never blocked with an empty output register
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("s_ready low with no pending result");

    // abort ends the NAL and drops ready status
    a_abort: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nal_abort |-> m_nal_last && !m_nal_first && !m_stream_ready)
        else $error("abort marks inconsistent");

    // first byte of a NAL has no type yet and cannot abort
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_nal_first |-> (m_nal_type == nalsp_pkg::TYPE_NONE) && !m_nal_abort)
        else $error("first byte with type or abort set");

endmodule

bind annexb_nal_unit_splitter_top nalsp_port_sva u_nalsp_port_sva (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_out_byte     (m_out_byte),
    .m_nal_first    (m_nal_first),
    .m_nal_last     (m_nal_last),
    .m_nal_type     (m_nal_type),
    .m_nal_abort    (m_nal_abort),
    .m_stream_ready (m_stream_ready)
);

`default_nettype wire
